>>> rtl/i2ctrf_pkg.sv
// Shared types and widths for the I2C target register file.
// Used by i2ctrf_bank, i2ctrf_ctrl and i2c_target_register_file.
package i2ctrf_pkg;

    localparam int ADDR_W  = 7;
    localparam int DATA_W  = 8;
    localparam int WIDX_W  = 3;
    localparam int STATE_W = 4;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [DATA_W-1:0] shift_data;
        logic              stop_seen;
    } t_item;

    typedef struct packed {
        logic               sda_drive;
        logic [DATA_W-1:0]  tx_byte;
        logic               single_bit_phase;
        logic [STATE_W-1:0] ctrl_state;
        logic               write_strobe;
        logic [WIDX_W-1:0]  write_index;
        logic [ADDR_W-1:0]  seen_address;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [DATA_W-1:0] wr_data;
        logic              ld_en;
        logic [DATA_W-1:0] ld_index;
    } t_bank_req;

endpackage

>>> rtl/i2ctrf_bank.sv
// Register bank: memory of NUM_REGS bytes with per-entry valid bits,
// selected index and registered read of the selected entry. Uses i2ctrf_pkg.
module i2ctrf_bank #(
    parameter int NUM_REGS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  i2ctrf_pkg::t_bank_req          i_req,
    output logic [i2ctrf_pkg::DATA_W-1:0]  o_sel_data,
    output logic [i2ctrf_pkg::DATA_W-1:0]  o_sel_index
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [i2ctrf_pkg::DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]           r_valid;
    logic [IDX_W-1:0]              r_index;
    logic [i2ctrf_pkg::DATA_W-1:0] r_sel_data;
    logic [IDX_W-1:0]              ld_addr;

    assign ld_addr = i_req.ld_index[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[r_index] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_index    <= '0;
            r_sel_data <= '0;
        end else if (i_req.wr_en) begin
            r_valid[r_index] <= 1'b1;
            r_sel_data       <= i_req.wr_data;
        end else if (i_req.ld_en) begin
            r_index    <= ld_addr;
            r_sel_data <= r_valid[ld_addr] ? r_mem[ld_addr] : '0;
        end
    end

    assign o_sel_data  = r_sel_data;
    assign o_sel_index = i2ctrf_pkg::DATA_W'(r_index);

endmodule

>>> rtl/i2ctrf_ctrl.sv
// Transaction state machine: address match, register select, write and
// read sequencing, result register. Uses i2ctrf_pkg; drives i2ctrf_bank.
module i2ctrf_ctrl #(
    parameter int NUM_REGS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  i2ctrf_pkg::t_item              i_item,
    input  logic                           i_cfg_we,
    input  logic [i2ctrf_pkg::ADDR_W-1:0]  i_cfg_data,
    input  logic [i2ctrf_pkg::DATA_W-1:0]  i_sel_data,
    input  logic [i2ctrf_pkg::DATA_W-1:0]  i_sel_index,
    output i2ctrf_pkg::t_bank_req          o_bank_req,
    output i2ctrf_pkg::t_result            o_res
);

    typedef enum logic [i2ctrf_pkg::STATE_W-1:0] {
        ST_IDLE      = 4'd0,
        ST_STARTED   = 4'd1,
        ST_ACK_ADDR  = 4'd2,
        ST_REG_SEL   = 4'd3,
        ST_ACK_REG   = 4'd4,
        ST_RD_WRITE  = 4'd5,
        ST_ACK_WRITE = 4'd6,
        ST_RESTARTED = 4'd7,
        ST_ACK_READ  = 4'd8,
        ST_WRITING   = 4'd9,
        ST_RD_ACK    = 4'd10,
        ST_NACKING   = 4'd11
    } t_state;

    t_state                        r_state, n_state;
    logic [i2ctrf_pkg::ADDR_W-1:0] r_own_address;
    logic [i2ctrf_pkg::ADDR_W-1:0] r_recent, n_recent;
    i2ctrf_pkg::t_result           r_res, n_res;
    logic [i2ctrf_pkg::ADDR_W-1:0] rx_addr;
    logic                          addr_ok;
    logic                          idx_ok;
    logic [i2ctrf_pkg::DATA_W-1:0] tx;
    logic                          single;
    logic                          strobe;

    assign rx_addr = i_item.shift_data[i2ctrf_pkg::DATA_W-1:1];
    assign addr_ok = rx_addr == r_own_address;
    assign idx_ok  = {1'b0, i_item.shift_data} < (i2ctrf_pkg::DATA_W + 1)'(NUM_REGS);

    always_comb begin
        n_state    = r_state;
        n_recent   = r_recent;
        tx         = '0;
        single     = 1'b0;
        strobe     = 1'b0;
        o_bank_req = '0;
        o_bank_req.wr_data  = i_item.shift_data;
        o_bank_req.ld_index = i_item.shift_data;
        if (i_item.operation == i2ctrf_pkg::OP_START) begin
            n_state = (r_state == ST_RD_WRITE) ? ST_RESTARTED : ST_STARTED;
        end else begin
            unique case (r_state)
                ST_STARTED: begin
                    n_recent = rx_addr;
                    if (addr_ok) begin
                        n_state = ST_ACK_ADDR;
                        single  = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_ACK_ADDR: n_state = ST_REG_SEL;
                ST_REG_SEL: begin
                    if (idx_ok) begin
                        n_state          = ST_ACK_REG;
                        o_bank_req.ld_en = i_adv;
                    end else begin
                        n_state = ST_NACKING;
                    end
                    single = 1'b1;
                end
                ST_ACK_REG: n_state = ST_RD_WRITE;
                ST_RD_WRITE: begin
                    o_bank_req.wr_en = i_adv;
                    strobe           = 1'b1;
                    n_state          = ST_ACK_WRITE;
                    single           = 1'b1;
                end
                ST_ACK_WRITE: n_state = i_item.stop_seen ? ST_IDLE : ST_RD_WRITE;
                ST_RESTARTED: begin
                    if (addr_ok) begin
                        n_state = ST_ACK_READ;
                        single  = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_ACK_READ: begin
                    tx      = i_sel_data;
                    n_state = ST_WRITING;
                end
                ST_WRITING: begin
                    n_state = ST_RD_ACK;
                    single  = 1'b1;
                end
                ST_RD_ACK: begin
                    if (i_item.shift_data != '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        tx      = i_sel_data;
                        n_state = ST_WRITING;
                    end
                end
                ST_NACKING: n_state = ST_IDLE;
                default: n_state = r_state;
            endcase
        end

        n_res.sda_drive        = n_state == ST_ACK_ADDR || n_state == ST_ACK_REG ||
                                 n_state == ST_ACK_WRITE || n_state == ST_ACK_READ ||
                                 n_state == ST_WRITING;
        n_res.tx_byte          = tx;
        n_res.single_bit_phase = single;
        n_res.ctrl_state       = n_state;
        n_res.write_strobe     = strobe;
        n_res.write_index      = strobe ? i_sel_index[i2ctrf_pkg::WIDX_W-1:0] : '0;
        n_res.seen_address     = n_recent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_recent      <= '0;
            r_own_address <= '0;
        end else begin
            if (i_cfg_we) begin
                r_own_address <= i_cfg_data;
            end
            if (i_adv) begin
                r_state  <= n_state;
                r_recent <= n_recent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/i2c_target_register_file.sv
// Top level of the I2C target register file: input word register,
// controller, register bank and result register. Uses i2ctrf_pkg.
//
// One bus event word is accepted per clock cycle while results are taken;
// each result word is registered (the input register feeds the
// controller, whose result register loads as the word advances). While a result
// waits, the input register takes one more word and then input ready drops.
// The register bank is a NUM_REGS-byte memory whose entries read as zero
// until first written, tracked by per-entry valid bits that reset clears
// at once, so the block is ready as soon as reset is released.
// The own-address register is written through the configuration channel,
// which is always ready.
module i2c_target_register_file #(
    parameter int NUM_REGS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [i2ctrf_pkg::DATA_W-1:0]  i_shift_data,
    input  logic                           i_stop_seen,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_sda_drive,
    output logic [i2ctrf_pkg::DATA_W-1:0]  o_tx_byte,
    output logic                           o_single_bit_phase,
    output logic [i2ctrf_pkg::STATE_W-1:0] o_ctrl_state,
    output logic                           o_write_strobe,
    output logic [i2ctrf_pkg::WIDX_W-1:0]  o_write_index,
    output logic [i2ctrf_pkg::ADDR_W-1:0]  o_seen_address,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [i2ctrf_pkg::ADDR_W-1:0]  i_cfg_data
);

    i2ctrf_pkg::t_item             r_item;
    logic                          r_item_valid;
    logic                          r_out_valid;
    logic                          adv;
    logic                          in_take;
    i2ctrf_pkg::t_bank_req         bank_req;
    i2ctrf_pkg::t_result           res;
    logic [i2ctrf_pkg::DATA_W-1:0] sel_data;
    logic [i2ctrf_pkg::DATA_W-1:0] sel_index;

    assign adv        = r_item_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_item_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_take) begin
                r_item_valid <= 1'b1;
            end else if (adv) begin
                r_item_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.operation  <= i_operation;
            r_item.shift_data <= i_shift_data;
            r_item.stop_seen  <= i_stop_seen;
        end
    end

    i2ctrf_ctrl #(
        .NUM_REGS (NUM_REGS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sel_data  (sel_data),
        .i_sel_index (sel_index),
        .o_bank_req  (bank_req),
        .o_res       (res)
    );

    i2ctrf_bank #(
        .NUM_REGS (NUM_REGS)
    ) u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (bank_req),
        .o_sel_data  (sel_data),
        .o_sel_index (sel_index)
    );

    assign o_out_valid        = r_out_valid;
    assign o_sda_drive        = res.sda_drive;
    assign o_tx_byte          = res.tx_byte;
    assign o_single_bit_phase = res.single_bit_phase;
    assign o_ctrl_state       = res.ctrl_state;
    assign o_write_strobe     = res.write_strobe;
    assign o_write_index      = res.write_index;
    assign o_seen_address     = res.seen_address;

endmodule

>>> verif/i2ctrf_checker.sv
// Checker for the I2C target register file: watches the event, result and
// address channels, keeps its own copy of the controller and register bank,
// and compares every result word. Depends on i2ctrf_pkg.
module i2ctrf_checker
    import i2ctrf_pkg::*;
#(
    parameter int NUM_REGS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_operation,
    input  logic [DATA_W-1:0]  i_shift_data,
    input  logic               i_stop_seen,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_sda_drive,
    input  logic [DATA_W-1:0]  i_tx_byte,
    input  logic               i_single_bit_phase,
    input  logic [STATE_W-1:0] i_ctrl_state,
    input  logic               i_write_strobe,
    input  logic [WIDX_W-1:0]  i_write_index,
    input  logic [ADDR_W-1:0]  i_seen_address,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [ADDR_W-1:0]  i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_writes,
    output int                 o_reads
);

    typedef enum logic [STATE_W-1:0] {
        C_IDLE, C_STARTED, C_ADDR_ACK, C_REG_SEL, C_REG_ACK, C_DATA_IN,
        C_DATA_ACK, C_RESTARTED, C_READ_ACK, C_DATA_OUT, C_MASTER_ACK, C_NACK
    } t_ctrl;

    t_ctrl             ctl = C_IDLE;
    logic [DATA_W-1:0] bank [NUM_REGS];
    logic [DATA_W-1:0] sel = '0;
    logic [ADDR_W-1:0] last_addr = '0;
    logic [ADDR_W-1:0] my_addr = '0;
    t_result           due_replies [$];
    t_result           got;
    t_result           want;
    int                n_fail = 0;
    int                n_results = 0;
    int                n_writes = 0;
    int                n_reads = 0;
    int                n_pending = 0;

    assign o_fail_count = n_fail;
    assign o_pending    = n_pending;
    assign o_results    = n_results;
    assign o_writes     = n_writes;
    assign o_reads      = n_reads;

    function automatic t_result advance_target(input t_item w);
        t_result r;
        logic    match;
        r = '0;
        match = (w.shift_data[DATA_W-1:1] == my_addr);
        if (w.operation == OP_START) begin
            ctl = (ctl == C_DATA_IN) ? C_RESTARTED : C_STARTED;
        end else begin
            case (ctl)
                C_STARTED: begin
                    last_addr = w.shift_data[DATA_W-1:1];
                    if (match) begin
                        ctl = C_ADDR_ACK;
                        r.single_bit_phase = 1'b1;
                    end else begin
                        ctl = C_IDLE;
                    end
                end
                C_ADDR_ACK: ctl = C_REG_SEL;
                C_REG_SEL: begin
                    if (int'(w.shift_data) < NUM_REGS) begin
                        sel = w.shift_data;
                        ctl = C_REG_ACK;
                    end else begin
                        ctl = C_NACK;
                    end
                    r.single_bit_phase = 1'b1;
                end
                C_REG_ACK: ctl = C_DATA_IN;
                C_DATA_IN: begin
                    bank[sel % NUM_REGS] = w.shift_data;
                    r.write_strobe = 1'b1;
                    r.write_index = sel[WIDX_W-1:0];
                    r.single_bit_phase = 1'b1;
                    ctl = C_DATA_ACK;
                    n_writes++;
                end
                C_DATA_ACK: ctl = w.stop_seen ? C_IDLE : C_DATA_IN;
                C_RESTARTED: begin
                    if (match) begin
                        ctl = C_READ_ACK;
                        r.single_bit_phase = 1'b1;
                    end else begin
                        ctl = C_IDLE;
                    end
                end
                C_READ_ACK: begin
                    r.tx_byte = bank[sel % NUM_REGS];
                    ctl = C_DATA_OUT;
                    n_reads++;
                end
                C_DATA_OUT: begin
                    ctl = C_MASTER_ACK;
                    r.single_bit_phase = 1'b1;
                end
                C_MASTER_ACK: begin
                    if (w.shift_data != '0) begin
                        ctl = C_IDLE;
                    end else begin
                        r.tx_byte = bank[sel % NUM_REGS];
                        ctl = C_DATA_OUT;
                        n_reads++;
                    end
                end
                C_NACK: ctl = C_IDLE;
                default: ;
            endcase
        end
        r.sda_drive = ctl inside {C_ADDR_ACK, C_REG_ACK, C_DATA_ACK, C_READ_ACK, C_DATA_OUT};
        r.ctrl_state = ctl;
        r.seen_address = last_addr;
        return r;
    endfunction

    task automatic compare_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctl = C_IDLE;
            sel = '0;
            last_addr = '0;
            my_addr = '0;
            for (int i = 0; i < NUM_REGS; i++) bank[i] = '0;
            due_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) my_addr = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got = {i_sda_drive, i_tx_byte, i_single_bit_phase, i_ctrl_state,
                       i_write_strobe, i_write_index, i_seen_address};
                n_results++;
                if (due_replies.size() == 0) begin
                    n_fail++;
                    $display("%0t: result word with none expected, expected nothing, got %0h",
                             $time, got);
                end else begin
                    want = due_replies.pop_front();
                    compare_field("sda_drive", want.sda_drive, got.sda_drive);
                    compare_field("tx_byte", want.tx_byte, got.tx_byte);
                    compare_field("single_bit_phase", want.single_bit_phase,
                                  got.single_bit_phase);
                    compare_field("ctrl_state", want.ctrl_state, got.ctrl_state);
                    compare_field("write_strobe", want.write_strobe, got.write_strobe);
                    compare_field("write_index", want.write_index, got.write_index);
                    compare_field("seen_address", want.seen_address, got.seen_address);
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_replies.push_back(advance_target({i_operation, i_shift_data, i_stop_seen}));
            end
        end
        n_pending = due_replies.size();
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the I2C target register file: clock, reset, bus event
// stimulus, address writes and verdict. Uses i2ctrf_pkg and i2ctrf_checker.
module tb_top;
    import i2ctrf_pkg::*;

    localparam int NUM_REGS    = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                i_operation = 1'b0;
    logic [DATA_W-1:0]   i_shift_data = '0;
    logic                i_stop_seen = 1'b0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_data = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_sda_drive;
    logic [DATA_W-1:0]   o_tx_byte;
    logic                o_single_bit_phase;
    logic [STATE_W-1:0]  o_ctrl_state;
    logic                o_write_strobe;
    logic [WIDX_W-1:0]   o_write_index;
    logic [ADDR_W-1:0]   o_seen_address;
    logic                o_cfg_ready;

    int                  fail_count;
    int                  pending;
    int                  results;
    int                  writes;
    int                  reads;
    int                  words_sent = 0;
    int                  quiet_cycles = 0;
    bit                  idle_on = 1'b1;
    bit                  hold_go = 1'b0;
    bit                  hold_done = 1'b0;
    logic [ADDR_W-1:0]   own_addr = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    i2c_target_register_file #(.NUM_REGS(NUM_REGS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_shift_data(i_shift_data), .i_stop_seen(i_stop_seen),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_sda_drive(o_sda_drive), .o_tx_byte(o_tx_byte),
        .o_single_bit_phase(o_single_bit_phase), .o_ctrl_state(o_ctrl_state),
        .o_write_strobe(o_write_strobe), .o_write_index(o_write_index),
        .o_seen_address(o_seen_address),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    i2ctrf_checker #(.NUM_REGS(NUM_REGS)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_operation(i_operation), .i_shift_data(i_shift_data), .i_stop_seen(i_stop_seen),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sda_drive(o_sda_drive), .i_tx_byte(o_tx_byte),
        .i_single_bit_phase(o_single_bit_phase), .i_ctrl_state(o_ctrl_state),
        .i_write_strobe(o_write_strobe), .i_write_index(o_write_index),
        .i_seen_address(o_seen_address),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results),
        .o_writes(writes), .o_reads(reads)
    );

    task automatic send_word(input logic op, input logic [DATA_W-1:0] data, input logic stop);
        bit took;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_shift_data <= data;
        i_stop_seen  <= stop;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        words_sent++;
    endtask

    task automatic pulse_start();
        send_word(OP_START, DATA_W'($urandom), 1'($urandom));
    endtask

    task automatic filler();
        send_word(OP_OVERFLOW, DATA_W'($urandom), 1'($urandom));
    endtask

    task automatic send_addr(input logic [ADDR_W-1:0] a);
        send_word(OP_OVERFLOW, {a, 1'($urandom)}, 1'($urandom));
    endtask

    task automatic open_register(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] idx);
        pulse_start();
        send_addr(a);
        filler();
        send_word(OP_OVERFLOW, idx, 1'($urandom));
        filler();
    endtask

    task automatic write_bytes(input int n, input bit finish);
        for (int i = 0; i < n; i++) begin
            send_word(OP_OVERFLOW, DATA_W'($urandom), 1'($urandom));
            send_word(OP_OVERFLOW, DATA_W'($urandom), finish && i == n - 1);
        end
    endtask

    task automatic read_back(input logic [ADDR_W-1:0] a, input int n);
        pulse_start();
        send_addr(a);
        if (n > 0) begin
            filler();
            for (int i = 0; i < n; i++) begin
                filler();
                send_word(OP_OVERFLOW, (i == n - 1) ? DATA_W'($urandom_range(1, 255)) : '0,
                          1'($urandom));
            end
        end
    endtask

    task automatic random_mix(input int target);
        int pick;
        logic [DATA_W-1:0] idx;
        while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            idx = DATA_W'($urandom_range(0, NUM_REGS - 1));
            if (pick < 40) begin
                open_register(own_addr, idx);
                write_bytes($urandom_range(1, 4), 1'b1);
            end else if (pick < 75) begin
                open_register(own_addr, idx);
                write_bytes($urandom_range(0, 2), 1'b0);
                if ($urandom_range(0, 9) == 0)
                    read_back(own_addr ^ ADDR_W'($urandom_range(1, 127)), 0);
                else
                    read_back(own_addr, $urandom_range(1, 4));
            end else if (pick < 85) begin
                open_register(own_addr, DATA_W'($urandom_range(NUM_REGS, 255)));
            end else if (pick < 90) begin
                pulse_start();
                send_addr(own_addr ^ ADDR_W'($urandom_range(1, 127)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom), DATA_W'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_own_address(input logic [ADDR_W-1:0] a);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= a;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        own_addr = a;
    endtask

    initial begin
        forever begin
            if (hold_go && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("** i2c_target_register_file: FAILED **");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // overflow while idle, then a write of two bytes to the top register
        send_word(OP_OVERFLOW, 8'hFF, 1'b1);
        send_word(OP_START, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h01, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h07, 1'b0);
        send_word(OP_OVERFLOW, 8'hFF, 1'b1);
        send_word(OP_OVERFLOW, 8'h00, 1'b1);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'hFF, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b1);
        drain();
        set_own_address(7'h7F);

        // refused index, then repeated start and a two-byte read ending in NACK
        send_word(OP_START, 8'hFF, 1'b1);
        send_word(OP_OVERFLOW, 8'hFE, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'hFF, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_START, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'hFF, 1'b1);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h07, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_START, 8'h00, 1'b1);
        send_word(OP_OVERFLOW, 8'hFE, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h00, 1'b0);
        send_word(OP_OVERFLOW, 8'h01, 1'b0);
        drain();

        set_own_address(ADDR_W'($urandom));
        hold_go = 1'b1;
        random_mix(300);
        drain();
        set_own_address('0);
        random_mix(550);
        drain();
        set_own_address(7'h7F);
        random_mix(800);
        drain();
        idle_on = 1'b0;
        set_own_address(ADDR_W'($urandom));
        random_mix(1100);
        drain();

        $display("run covered %0d bus event words and %0d result words", words_sent, results);
        $display("with %0d register writes and %0d read bytes across several own addresses",
                 writes, reads);
        if (fail_count == 0)
            $display("** i2c_target_register_file: PASSED **");
        else
            $display("** i2c_target_register_file: FAILED **");
        $finish;
    end

endmodule
